>>> design/srmd_pkg.sv
// ----------------------------------------------------------------------------
// Sorted run merge package
// Shared constants, opcodes, command kinds and state types of the merge block.
// ----------------------------------------------------------------------------
package srmd_pkg;

	localparam int FIELD_BITS       = 32;
	localparam int OPCODE_BITS      = 2;
	localparam int DEF_RUN_DEPTH    = 32;
	localparam int DEF_KEY_BITS     = 32;
	localparam int DEF_SEQ_BITS     = 32;
	localparam int DEF_PAYLOAD_BITS = 32;
	localparam int CMD_FIFO_DEPTH   = 2;

	localparam logic [OPCODE_BITS-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OPCODE_BITS-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OPCODE_BITS-1:0] OP_MERGE  = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_A,
		CMD_LOAD_B,
		CMD_MERGE
	} cmd_kind_t;

	localparam int CMD_KIND_BITS = $bits(cmd_kind_t);

	typedef enum logic {
		BK_IDLE,
		BK_MERGE
	} back_state_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_status_t;

endpackage

>>> design/srmd_in_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries load and merge commands into the block.
// ----------------------------------------------------------------------------
interface srmd_in_if;
	import srmd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OPCODE_BITS-1:0] opcode;
	logic [FIELD_BITS-1:0]  entry_key;
	logic [FIELD_BITS-1:0]  entry_seq;
	logic [FIELD_BITS-1:0]  entry_payload;

	modport source (output valid, opcode, entry_key, entry_seq, entry_payload, input ready);
	modport sink (input valid, opcode, entry_key, entry_seq, entry_payload, output ready);

endinterface

>>> design/srmd_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries merged entries out of the block.
// ----------------------------------------------------------------------------
interface srmd_out_if;
	import srmd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] out_key;
	logic [FIELD_BITS-1:0] out_seq;
	logic [FIELD_BITS-1:0] out_payload;
	logic                  out_last;

	modport source (output valid, out_key, out_seq, out_payload, out_last, input ready);
	modport sink (input valid, out_key, out_seq, out_payload, out_last, output ready);

endinterface

>>> design/srmd_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, decodes the opcode and fits the entry fields to the
// stored widths before handing the command to the command queue.
// ----------------------------------------------------------------------------
module srmd_front #(
	parameter int KEY_BITS     = 32,
	parameter int SEQ_BITS     = 32,
	parameter int PAYLOAD_BITS = 32,
	parameter int CMD_BITS     = 98
) (
	srmd_in_if.sink              ingress,
	input  srmd_pkg::fifo_status_t fifo_status,
	output logic                 push,
	output logic [CMD_BITS-1:0]  push_data
);
	import srmd_pkg::*;

	cmd_kind_t kind;
	logic      known;

	assign ingress.ready = !fifo_status.full;

	always_comb begin
		kind  = CMD_MERGE;
		known = 1'b1;
		unique case (ingress.opcode)
			OP_LOAD_A: kind = CMD_LOAD_A;
			OP_LOAD_B: kind = CMD_LOAD_B;
			OP_MERGE:  kind = CMD_MERGE;
			default:   known = 1'b0;
		endcase
	end

	// Reserved opcodes are taken off the channel and dropped here.
	assign push      = ingress.valid && ingress.ready && known;
	assign push_data = {kind,
	                    PAYLOAD_BITS'(ingress.entry_payload),
	                    SEQ_BITS'(ingress.entry_seq),
	                    KEY_BITS'(ingress.entry_key)};

endmodule

>>> design/srmd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short register queue between the front end and the merge engine.
// ----------------------------------------------------------------------------
module srmd_cmd_fifo #(
	parameter int WIDTH = 98
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       push_data,
	input  logic                   pop,
	output logic [WIDTH-1:0]       pop_data,
	output srmd_pkg::fifo_status_t status
);
	import srmd_pkg::*;

	localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
	localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [CMD_FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
		return (ptr == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign status.full      = (fill_q == CW'(CMD_FIFO_DEPTH));
	assign status.not_empty = (fill_q != '0);
	assign pop_data         = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			fill_q <= fill_q + CW'(push) - CW'(pop);
		end
	end

endmodule

>>> design/srmd_back.sv
// ----------------------------------------------------------------------------
// Merge engine
// Holds both run stores, carries out loads, and walks the two runs in key
// order on a merge, driving the result register.
// ----------------------------------------------------------------------------
module srmd_back #(
	parameter int RUN_DEPTH    = 32,
	parameter int KEY_BITS     = 32,
	parameter int SEQ_BITS     = 32,
	parameter int PAYLOAD_BITS = 32,
	parameter int CMD_BITS     = 98
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srmd_pkg::fifo_status_t fifo_status,
	input  logic [CMD_BITS-1:0]    cmd_data,
	output logic                   pop,
	srmd_out_if.source             egress
);
	import srmd_pkg::*;

	localparam int EW = KEY_BITS + SEQ_BITS + PAYLOAD_BITS;
	localparam int CW = $clog2(RUN_DEPTH + 1);
	localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

	logic [EW-1:0] mem_a [RUN_DEPTH];
	logic [EW-1:0] mem_b [RUN_DEPTH];
	logic [EW-1:0] head_a_q;
	logic [EW-1:0] head_b_q;

	back_state_t state_q, state_d;
	logic [CW-1:0] count_a_q, count_b_q;
	logic [CW-1:0] ia_q, ia_d, ib_q, ib_d;

	logic                    out_valid_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [SEQ_BITS-1:0]     out_seq_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic                    out_last_q;

	cmd_kind_t     cmd_kind;
	logic [EW-1:0] cmd_entry;
	logic wr_a, wr_b, emit, take_a, adv_a, adv_b, last, clr;
	logic have_a, have_b, out_free;
	logic [KEY_BITS-1:0] key_a, key_b;
	logic [SEQ_BITS-1:0] seq_a, seq_b;

	assign cmd_kind  = cmd_kind_t'(cmd_data[EW +: CMD_KIND_BITS]);
	assign cmd_entry = cmd_data[EW-1:0];

	assign key_a    = head_a_q[KEY_BITS-1:0];
	assign key_b    = head_b_q[KEY_BITS-1:0];
	assign seq_a    = head_a_q[KEY_BITS +: SEQ_BITS];
	assign seq_b    = head_b_q[KEY_BITS +: SEQ_BITS];
	assign have_a   = ia_q < count_a_q;
	assign have_b   = ib_q < count_b_q;
	assign out_free = !out_valid_q || egress.ready;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		wr_a    = 1'b0;
		wr_b    = 1'b0;
		emit    = 1'b0;
		take_a  = 1'b0;
		adv_a   = 1'b0;
		adv_b   = 1'b0;
		clr     = 1'b0;
		last    = 1'b0;
		ia_d    = ia_q;
		ib_d    = ib_q;
		unique case (state_q)
			BK_IDLE: begin
				if (fifo_status.not_empty) begin
					pop = 1'b1;
					unique case (cmd_kind)
						CMD_LOAD_A: wr_a = count_a_q < CW'(RUN_DEPTH);
						CMD_LOAD_B: wr_b = count_b_q < CW'(RUN_DEPTH);
						CMD_MERGE: begin
							// A merge of two empty runs gives nothing.
							if (count_a_q != '0 || count_b_q != '0) begin
								state_d = BK_MERGE;
							end
						end
						default: ;
					endcase
				end
			end
			BK_MERGE: begin
				if (out_free) begin
					emit = 1'b1;
					if (have_a && have_b) begin
						if (key_a < key_b) begin
							take_a = 1'b1;
							adv_a  = 1'b1;
						end else if (key_a > key_b) begin
							adv_b = 1'b1;
						end else begin
							// Equal keys: the newer entry survives, run A on a tie.
							take_a = seq_a >= seq_b;
							adv_a  = 1'b1;
							adv_b  = 1'b1;
						end
					end else begin
						take_a = have_a;
						adv_a  = have_a;
						adv_b  = !have_a;
					end
					ia_d = ia_q + CW'(adv_a);
					ib_d = ib_q + CW'(adv_b);
					last = (ia_d == count_a_q) && (ib_d == count_b_q);
					if (last) begin
						state_d = BK_IDLE;
						clr     = 1'b1;
						ia_d    = '0;
						ib_d    = '0;
					end
				end
			end
		endcase
	end

	// The head registers always read the entry at the next index, so the
	// current head is ready in the cycle after an advance.
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[count_a_q[AW-1:0]] <= cmd_entry;
		end
		if (wr_b) begin
			mem_b[count_b_q[AW-1:0]] <= cmd_entry;
		end
		head_a_q <= mem_a[ia_d[AW-1:0]];
		head_b_q <= mem_b[ib_d[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ia_q      <= ia_d;
			ib_q      <= ib_d;
			count_a_q <= clr ? '0 : count_a_q + CW'(wr_a);
			count_b_q <= clr ? '0 : count_b_q + CW'(wr_b);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (egress.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_key_q  <= take_a ? key_a : key_b;
			out_seq_q  <= take_a ? seq_a : seq_b;
			out_pay_q  <= take_a ? head_a_q[KEY_BITS+SEQ_BITS +: PAYLOAD_BITS]
			                     : head_b_q[KEY_BITS+SEQ_BITS +: PAYLOAD_BITS];
			out_last_q <= last;
		end
	end

	assign egress.valid       = out_valid_q;
	assign egress.out_key     = FIELD_BITS'(out_key_q);
	assign egress.out_seq     = FIELD_BITS'(out_seq_q);
	assign egress.out_payload = FIELD_BITS'(out_pay_q);
	assign egress.out_last    = out_last_q;

endmodule

>>> design/sorted_run_merge_dedup.sv
// ----------------------------------------------------------------------------
// Sorted run merge with sequence deduplication
// Two-way merge of key-sorted runs, keeping the newest entry of each key.
// ----------------------------------------------------------------------------
// Usage: commands arrive on ingress (valid/ready). Opcode load A or load B
// appends the entry to that run, and a load into a full run is dropped.
// Opcode merge walks both runs and sends one transaction per surviving entry
// on egress, smallest key first, out_last marking the final one; both runs are
// then empty. A merge of two empty runs sends nothing; opcode 3 is ignored.
// Commands pass a two-entry queue, so ingress takes up to two more commands
// while the merge engine works or waits. The engine takes one load per cycle
// while no merge is running. A merge command passes the queue and the engine
// state, and its results leave through the result register, one result per
// cycle while egress is ready. When egress stalls, the result register holds
// its transaction and the merge pauses. Reset empties both runs and the queue
// and drops any pending result; stored entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_run_merge_dedup #(
	parameter int RUN_DEPTH    = srmd_pkg::DEF_RUN_DEPTH,
	parameter int KEY_BITS     = srmd_pkg::DEF_KEY_BITS,
	parameter int SEQ_BITS     = srmd_pkg::DEF_SEQ_BITS,
	parameter int PAYLOAD_BITS = srmd_pkg::DEF_PAYLOAD_BITS
) (
	input logic        clk,
	input logic        arst_n,
	srmd_in_if.sink    ingress,
	srmd_out_if.source egress
);
	import srmd_pkg::*;

	localparam int CMD_BITS = CMD_KIND_BITS + KEY_BITS + SEQ_BITS + PAYLOAD_BITS;

	logic                push;
	logic                pop;
	logic [CMD_BITS-1:0] push_data;
	logic [CMD_BITS-1:0] pop_data;
	fifo_status_t        fifo_status;

	srmd_front #(
		.KEY_BITS    (KEY_BITS),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.CMD_BITS    (CMD_BITS)
	) u_front (
		.ingress    (ingress),
		.fifo_status(fifo_status),
		.push       (push),
		.push_data  (push_data)
	);

	srmd_cmd_fifo #(
		.WIDTH(CMD_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (fifo_status)
	);

	srmd_back #(
		.RUN_DEPTH   (RUN_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.CMD_BITS    (CMD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_status(fifo_status),
		.cmd_data   (pop_data),
		.pop        (pop),
		.egress     (egress)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fifo_status.not_empty)
		else $error("command popped from an empty queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_status.full)
		else $error("command pushed into a full queue");

	a_merge_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(ingress.valid && ingress.ready && ingress.opcode == OP_MERGE)
		|=> fifo_status.not_empty)
		else $error("accepted merge command missing from the queue");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> !fifo_status.full)
		else $error("queue still full after a pop");

endmodule
